[sv/rpsbb_pkg.sv]
package rpsbb_pkg;

  // coordinate and quaternion formats
  localparam int CW       = 32;              // coordinate width, Q16.16
  localparam int QFB      = 14;              // quaternion fraction bits
  localparam int QW       = 16;              // quaternion register width
  localparam int HALF_W   = CW - 1;          // half extent width
  localparam int MAT_W    = 2 * QW + 4;      // matrix entry before clamping
  localparam int ENTRY_W  = 2 * QFB + 3;     // clamped entry, range +-2.0
  localparam int PROD_W   = ENTRY_W + CW;    // one matrix product
  localparam int ACC_W    = PROD_W + 2;      // sum of three products

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CW;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W   = 3'd0,
    REG_QUAT_X   = 3'd1,
    REG_QUAT_Y   = 3'd2,
    REG_QUAT_Z   = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_OFFSET_Z = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_OFFS,
    BK_HALF,
    BK_LOAD
  } bk_state_t;

  // one rotated point as it travels from front to back
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 last;
  } rot_pt_t;

  typedef struct packed {
    logic    valid;
    rot_pt_t pt;
  } rot_beat_t;

endpackage

[sv/rotated_point_set_bounding_box_unit.sv]
// channel | direction | handshake         | beat
// in_     | input     | in_valid/in_stall   | point_x/y/z, last_point
// out_    | output    | out_valid/out_stall | box min/max, center, half per axis
// cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// A point moves through three front stages (capture, multiply, round) into a
// four-deep queue; the back end takes one queued point per cycle into the min/max.
// Steady rate is one point per cycle while accumulating; a set's last point is
// followed by offset add, halving and output load before the next set is reduced.
// Reset (synchronous, rst_n low) empties the pipe and queue and restores the
// identity rotation and zero offset. out_stall holds the result register and
// backs up the queue, then the front pipe, then in_stall.
module rotated_point_set_bounding_box_unit import rpsbb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [CW-1:0]   in_point_x,
  input  logic signed [CW-1:0]   in_point_y,
  input  logic signed [CW-1:0]   in_point_z,
  input  logic                   in_last_point,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CW-1:0]   out_box_min_x,
  output logic signed [CW-1:0]   out_box_min_y,
  output logic signed [CW-1:0]   out_box_min_z,
  output logic signed [CW-1:0]   out_box_max_x,
  output logic signed [CW-1:0]   out_box_max_y,
  output logic signed [CW-1:0]   out_box_max_z,
  output logic signed [CW-1:0]   out_center_x,
  output logic signed [CW-1:0]   out_center_y,
  output logic signed [CW-1:0]   out_center_z,
  output logic [HALF_W-1:0]      out_half_x,
  output logic [HALF_W-1:0]      out_half_y,
  output logic [HALF_W-1:0]      out_half_z
);

  rot_beat_t push;
  rot_beat_t head;
  logic      q_full;
  logic      pop;

  rpsbb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_last_point (in_last_point),
    .push_o        (push),
    .q_full        (q_full)
  );

  rpsbb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .q_full (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  rpsbb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_box_min_x (out_box_min_x),
    .out_box_min_y (out_box_min_y),
    .out_box_min_z (out_box_min_z),
    .out_box_max_x (out_box_max_x),
    .out_box_max_y (out_box_max_y),
    .out_box_max_z (out_box_max_z),
    .out_center_x  (out_center_x),
    .out_center_y  (out_center_y),
    .out_center_z  (out_center_z),
    .out_half_x    (out_half_x),
    .out_half_y    (out_half_y),
    .out_half_z    (out_half_z)
  );

endmodule

[sv/rpsbb_front.sv]
module rpsbb_front import rpsbb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [CW-1:0]  in_point_x,
  input  logic signed [CW-1:0]  in_point_y,
  input  logic signed [CW-1:0]  in_point_z,
  input  logic                  in_last_point,
  output rot_beat_t             push_o,
  input  logic                  q_full
);

  localparam logic signed [MAT_W-1:0]   MAT_ONE   = MAT_W'(1) << (2 * QFB);
  localparam logic signed [MAT_W-1:0]   ENTRY_LIM = MAT_W'(1) << (2 * QFB + 1);
  localparam logic signed [ACC_W-1:0]   ROUND     = ACC_W'(1) << (2 * QFB - 1);
  localparam logic signed [CW-1:0]      COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]      COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [ENTRY_W-1:0] clamp_entry(input logic signed [MAT_W-1:0] e);
    logic signed [MAT_W-1:0] c;
    c = e;
    if (e > ENTRY_LIM) c = ENTRY_LIM;
    else if (e < -ENTRY_LIM) c = -ENTRY_LIM;
    return c[ENTRY_W-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v[ACC_W-1:CW-1] == '0 || v[ACC_W-1:CW-1] == '1) r = v[CW-1:0];
    else if (v[ACC_W-1]) r = COORD_MIN;
    else r = COORD_MAX;
    return r;
  endfunction

  logic signed [QW-1:0] qw_r, qx_r, qy_r, qz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r <= QW'(1) << QFB;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUAT_W: qw_r <= cfg_data[QW-1:0];
        REG_QUAT_X: qx_r <= cfg_data[QW-1:0];
        REG_QUAT_Y: qy_r <= cfg_data[QW-1:0];
        REG_QUAT_Z: qz_r <= cfg_data[QW-1:0];
        default: ;
      endcase
    end
  end

  // rotation matrix, rebuilt every cycle from the quaternion registers
  logic signed [2*QW-1:0]    xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [MAT_W-1:0]   e [9];
  logic signed [ENTRY_W-1:0] m_nxt [9];
  logic signed [ENTRY_W-1:0] m_r   [9];

  assign xx = qx_r * qx_r;
  assign yy = qy_r * qy_r;
  assign zz = qz_r * qz_r;
  assign xy = qx_r * qy_r;
  assign xz = qx_r * qz_r;
  assign yz = qy_r * qz_r;
  assign wx = qw_r * qx_r;
  assign wy = qw_r * qy_r;
  assign wz = qw_r * qz_r;

  always_comb begin
    e[0] = MAT_ONE - ((MAT_W'(yy) + MAT_W'(zz)) <<< 1);
    e[1] = (MAT_W'(xy) - MAT_W'(wz)) <<< 1;
    e[2] = (MAT_W'(xz) + MAT_W'(wy)) <<< 1;
    e[3] = (MAT_W'(xy) + MAT_W'(wz)) <<< 1;
    e[4] = MAT_ONE - ((MAT_W'(xx) + MAT_W'(zz)) <<< 1);
    e[5] = (MAT_W'(yz) - MAT_W'(wx)) <<< 1;
    e[6] = (MAT_W'(xz) - MAT_W'(wy)) <<< 1;
    e[7] = (MAT_W'(yz) + MAT_W'(wx)) <<< 1;
    e[8] = MAT_ONE - ((MAT_W'(xx) + MAT_W'(yy)) <<< 1);
    for (int i = 0; i < 9; i++) m_nxt[i] = clamp_entry(e[i]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) m_r[i] <= m_nxt[i];
  end

  // three-stage pipe: capture, multiply, sum and round
  logic                 a_valid_r, b_valid_r, c_valid_r;
  logic                 a_last_r, b_last_r, c_last_r;
  logic signed [CW-1:0] a_pt_r [3];
  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [CW-1:0] c_pt_r [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [ACC_W-1:0]  shifted [3];
  logic                 a_free, b_free, c_free;

  assign c_free   = !c_valid_r || !q_full;
  assign b_free   = !b_valid_r || c_free;
  assign a_free   = !a_valid_r || b_free;
  assign in_stall = !a_free;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = ACC_W'(prod_r[3*r]) + ACC_W'(prod_r[3*r+1]) + ACC_W'(prod_r[3*r+2]) + ROUND;
      shifted[r] = acc[r] >>> (2 * QFB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_free) a_valid_r <= in_valid;
      if (b_free) b_valid_r <= a_valid_r;
      if (c_free) c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_pt_r[0] <= in_point_x;
      a_pt_r[1] <= in_point_y;
      a_pt_r[2] <= in_point_z;
      a_last_r  <= in_last_point;
    end
    if (b_free) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) prod_r[3*r+c] <= m_r[3*r+c] * a_pt_r[c];
      end
      b_last_r <= a_last_r;
    end
    if (c_free) begin
      for (int r = 0; r < 3; r++) c_pt_r[r] <= sat_coord(shifted[r]);
      c_last_r <= b_last_r;
    end
  end

  always_comb begin
    push_o.valid   = c_valid_r && !q_full;
    push_o.pt.x    = c_pt_r[0];
    push_o.pt.y    = c_pt_r[1];
    push_o.pt.z    = c_pt_r[2];
    push_o.pt.last = c_last_r;
  end

endmodule

[sv/rpsbb_queue.sv]
module rpsbb_queue import rpsbb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  rot_beat_t push_i,
  output logic      q_full,
  output rot_beat_t head_o,
  input  logic      pop_i
);

  rot_pt_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_pop;

  assign q_full = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign do_pop = pop_i && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i.valid && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push_i.valid && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.valid) mem_r[wr_ptr_r] <= push_i.pt;
  end

  assign head_o.valid = (cnt_r != '0);
  assign head_o.pt    = mem_r[rd_ptr_r];

endmodule

[sv/rpsbb_back.sv]
module rpsbb_back import rpsbb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  rot_beat_t              head_i,
  output logic                   pop_o,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CW-1:0]   out_box_min_x,
  output logic signed [CW-1:0]   out_box_min_y,
  output logic signed [CW-1:0]   out_box_min_z,
  output logic signed [CW-1:0]   out_box_max_x,
  output logic signed [CW-1:0]   out_box_max_y,
  output logic signed [CW-1:0]   out_box_max_z,
  output logic signed [CW-1:0]   out_center_x,
  output logic signed [CW-1:0]   out_center_y,
  output logic signed [CW-1:0]   out_center_z,
  output logic [HALF_W-1:0]      out_half_x,
  output logic [HALF_W-1:0]      out_half_y,
  output logic [HALF_W-1:0]      out_half_z
);

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    logic signed [CW-1:0] r;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] == s[CW-1]) r = s[CW-1:0];
    else if (s[CW]) r = COORD_MIN;
    else r = COORD_MAX;
    return r;
  endfunction

  bk_state_t state_r, state_nxt;

  logic signed [CW-1:0] off_r [3];
  logic signed [CW-1:0] min_r [3];
  logic signed [CW-1:0] max_r [3];
  logic signed [CW-1:0] lo_r  [3];
  logic signed [CW-1:0] hi_r  [3];
  logic [HALF_W-1:0]    half_r [3];
  logic signed [CW-1:0] diff  [3];
  logic signed [CW-1:0] v     [3];
  logic                 first_r;
  logic                 out_free;
  logic                 load_out;
  logic                 out_valid_r;

  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  assign v[0] = head_i.pt.x;
  assign v[1] = head_i.pt.y;
  assign v[2] = head_i.pt.z;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_ACC:  if (pop_o && head_i.pt.last) state_nxt = BK_OFFS;
      BK_OFFS: state_nxt = BK_HALF;
      BK_HALF: state_nxt = BK_LOAD;
      BK_LOAD: if (out_free) state_nxt = BK_ACC;
      default: state_nxt = BK_ACC;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      BK_ACC:  pop_o = head_i.valid;
      BK_LOAD: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_X: off_r[0] <= cfg_data;
        REG_OFFSET_Y: off_r[1] <= cfg_data;
        REG_OFFSET_Z: off_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_ACC;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop_o) first_r <= head_i.pt.last;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) diff[i] = hi_r[i] - lo_r[i];
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      for (int i = 0; i < 3; i++) begin
        if (first_r || v[i] < min_r[i]) min_r[i] <= v[i];
        if (first_r || v[i] > max_r[i]) max_r[i] <= v[i];
      end
    end
    if (state_r == BK_OFFS) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= sat_add(min_r[i], off_r[i]);
        hi_r[i] <= sat_add(max_r[i], off_r[i]);
      end
    end
    // upper corner never lies below the lower one, so the difference fits unsigned
    if (state_r == BK_HALF) begin
      for (int i = 0; i < 3; i++) half_r[i] <= diff[i][CW-1:1];
    end
    if (load_out) begin
      out_box_min_x <= lo_r[0];
      out_box_min_y <= lo_r[1];
      out_box_min_z <= lo_r[2];
      out_box_max_x <= hi_r[0];
      out_box_max_y <= hi_r[1];
      out_box_max_z <= hi_r[2];
      out_center_x  <= lo_r[0] + {1'b0, half_r[0]};
      out_center_y  <= lo_r[1] + {1'b0, half_r[1]};
      out_center_z  <= lo_r[2] + {1'b0, half_r[2]};
      out_half_x    <= half_r[0];
      out_half_y    <= half_r[1];
      out_half_z    <= half_r[2];
    end
  end

endmodule

[sv/rpsbb_checker.sv]
module rpsbb_checker import rpsbb_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic signed [CW-1:0]  out_box_min_x,
  input logic signed [CW-1:0]  out_box_max_x,
  input logic signed [CW-1:0]  out_center_x,
  input logic [HALF_W-1:0]     out_half_x
);

  logic signed [CW-1:0] span_x;
  assign span_x = out_box_max_x - out_box_min_x;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_box_min_x) && $stable(out_center_x))
    else $error("stalled result beat changed");

  a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_box_min_x <= out_box_max_x)
    else $error("lower corner above upper corner");

  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_half_x == span_x[CW-1:1])
    else $error("half extent does not match corners");

  a_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_center_x == out_box_min_x + {1'b0, out_half_x})
    else $error("center does not match corners");

endmodule

bind rotated_point_set_bounding_box_unit rpsbb_checker u_rpsbb_checker (.*);
